[rtl/core/bbe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bark band energy package
// Build-time constants, the Bark band tables and the command and status types
// shared by the controller and the datapath modules.
// ----------------------------------------------------------------------------
package bbe_pkg;

    localparam int FFT_SIZE    = 1024;
    localparam int BAND_COUNT  = 25;
    localparam int SAMPLE_BITS = 24;

    localparam int HALF_BINS  = FFT_SIZE / 2;
    localparam int BAND_BITS  = 5;
    localparam int WIDTH_W    = $clog2(HALF_BINS + 1);
    localparam int PWR_W      = 2 * SAMPLE_BITS;
    localparam int ACC_W      = 57;
    localparam int SUM_W      = ((PWR_W > ACC_W) ? PWR_W : ACC_W) + 1;
    localparam int VALUE_W    = 50;
    localparam int EXP_W      = 6;
    localparam int MANT_W     = 31;
    localparam int FRAC_W     = 30;
    localparam int SQR_IDX_W  = 5;
    localparam int LOGD_W     = 36;
    localparam int LOGL_W     = EXP_W + FRAC_W + 2;
    localparam int MAG_W      = LOGL_W - 8;
    localparam int TEN_LOG_W  = 18;
    localparam int LPROD_W    = MAG_W + TEN_LOG_W;
    localparam int Q_W        = LPROD_W + 1 - 30;
    localparam int CNT_W      = $clog2(ACC_W);
    localparam int SQR_STEPS  = 30;

    localparam int S_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((VALUE_W + BAND_BITS + 7) / 8) * 8;

    localparam logic [ACC_W-1:0]        ENERGY_MAX  = {ACC_W{1'b1}};
    localparam logic [VALUE_W-1:0]      LIN_MAX     = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0]      DB_FLOOR    = VALUE_W'(-24576);
    localparam logic [TEN_LOG_W-1:0]    TEN_LOG10_2 = TEN_LOG_W'(197283);
    localparam logic [LPROD_W:0]        ROUND_HALF  = (LPROD_W+1)'(1) << 29;
    localparam logic [EXP_W-1:0]        EXP_TOP     = EXP_W'(ACC_W - 1);

    localparam longint unsigned A1_DEN = 64'd1000 * FFT_SIZE;
    localparam longint unsigned T_DEN  = 64'd100 * FFT_SIZE;

    localparam longint CORDIC_ANGLE [31] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1
    };

    typedef logic [BAND_COUNT-1:0][WIDTH_W-1:0]   width_table_t;
    typedef logic [BAND_COUNT-1:0][BAND_BITS-1:0] band_table_t;
    typedef logic [BAND_COUNT-1:0][LOGD_W-1:0]    logd_table_t;
    typedef logic [BAND_COUNT-1:0]                flag_table_t;

    typedef struct packed {
        logic take;
        logic clear;
    } acc_cmd_t;

    typedef struct packed {
        logic pipe_busy;
    } acc_sts_t;

    typedef struct packed {
        logic                 load;
        logic                 div_step;
        logic                 norm_step;
        logic                 sqr_step;
        logic [SQR_IDX_W-1:0] sqr_bit;
        logic                 log_sub;
        logic                 log_mul;
        logic                 out_load;
        logic                 linear;
        logic [BAND_BITS-1:0] band;
        logic                 last;
    } math_cmd_t;

    typedef struct packed {
        logic norm_top;
        logic is_zero;
    } math_sts_t;

    // Arctangent of a non-negative Q30 argument by CORDIC, result in Q30.
    function automatic longint atan_q30(input longint arg);
        longint x;
        longint y;
        longint ang;
        longint nx;
        int     k;
        x   = longint'(1) <<< 30;
        y   = arg;
        ang = 0;
        if (arg <= 0)
        begin
            return 0;
        end
        for (k = 0; k < 31; k++)
        begin
            if (y > 0)
            begin
                nx  = x + (y >>> k);
                y   = y - (x >>> k);
                ang = ang + CORDIC_ANGLE[k];
            end
            else
            begin
                nx  = x - (y >>> k);
                y   = y + (x >>> k);
                ang = ang - CORDIC_ANGLE[k];
            end
            x = nx;
        end
        return ang;
    endfunction

    // Base-two logarithm in Q30 by repeated squaring of the mantissa.
    function automatic longint log2_q30(input longint unsigned v);
        int               p;
        int               k;
        longint unsigned  m;
        longint           f;
        p = 63;
        f = 0;
        while ((p > 0) && (((v >> p) & 64'd1) == 64'd0))
        begin
            p--;
        end
        m = (p > 30) ? (v >> (p - 30)) : (v << (30 - p));
        for (k = 30; k > 0; k--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                f = f | (longint'(1) <<< (k - 1));
            end
        end
        return (longint'(p) <<< 30) + f;
    endfunction

    function automatic width_table_t calc_widths();
        width_table_t    w;
        longint unsigned i;
        longint unsigned t;
        longint          a1;
        longint          a2;
        longint          z;
        longint          band;
        w = '0;
        for (i = 0; i < HALF_BINS; i++)
        begin
            a1 = longint'(((i * 64'd33516) << 30) / A1_DEN);
            t  = ((i * 64'd588) << 24) / T_DEN;
            a2 = longint'((t * t) >> 18);
            z  = 13 * atan_q30(a1) + ((7 * atan_q30(a2)) >>> 1);
            band = (z < 0) ? 0 : (z >>> 30);
            if (band > BAND_COUNT - 1)
            begin
                band = BAND_COUNT - 1;
            end
            w[band] = w[band] + WIDTH_W'(1);
        end
        return w;
    endfunction

    localparam width_table_t BAND_WIDTH = calc_widths();

    function automatic logic [BAND_BITS-1:0] calc_first();
        logic [BAND_BITS-1:0] fb;
        logic                 found;
        int                   j;
        fb    = '0;
        found = 1'b0;
        for (j = 0; j < BAND_COUNT; j++)
        begin
            if (!found && (BAND_WIDTH[j] != '0))
            begin
                fb    = BAND_BITS'(j);
                found = 1'b1;
            end
        end
        return fb;
    endfunction

    localparam logic [BAND_BITS-1:0] FIRST_BAND = calc_first();

    function automatic band_table_t calc_next();
        band_table_t nb;
        logic        found;
        int          b;
        int          j;
        nb = '0;
        for (b = 0; b < BAND_COUNT; b++)
        begin
            found = 1'b0;
            nb[b] = FIRST_BAND;
            for (j = b + 1; j < BAND_COUNT; j++)
            begin
                if (!found && (BAND_WIDTH[j] != '0))
                begin
                    nb[b] = BAND_BITS'(j);
                    found = 1'b1;
                end
            end
        end
        return nb;
    endfunction

    function automatic flag_table_t calc_last();
        flag_table_t lb;
        int          b;
        int          j;
        lb = '1;
        for (b = 0; b < BAND_COUNT; b++)
        begin
            for (j = b + 1; j < BAND_COUNT; j++)
            begin
                if (BAND_WIDTH[j] != '0)
                begin
                    lb[b] = 1'b0;
                end
            end
        end
        return lb;
    endfunction

    function automatic logd_table_t calc_log_den();
        logd_table_t     d;
        longint unsigned w;
        int              b;
        d = '0;
        for (b = 0; b < BAND_COUNT; b++)
        begin
            w    = (BAND_WIDTH[b] == '0) ? 64'd1 : 64'(BAND_WIDTH[b]);
            d[b] = LOGD_W'(log2_q30(w * 64'd96));
        end
        return d;
    endfunction

    localparam band_table_t NEXT_BAND = calc_next();
    localparam flag_table_t LAST_BAND = calc_last();
    localparam logd_table_t LOG_DEN   = calc_log_den();

endpackage

[rtl/core/bbe_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bark band energy accumulator
// Three-stage bin pipeline: capture, magnitude squaring, saturating band sum.
// ----------------------------------------------------------------------------
module bbe_accum (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bbe_pkg::acc_cmd_t                    cmd,
    input  logic signed [bbe_pkg::SAMPLE_BITS-1:0] real_part,
    input  logic signed [bbe_pkg::SAMPLE_BITS-1:0] imag_part,
    output bbe_pkg::acc_sts_t                    sts,
    output logic        [bbe_pkg::ACC_W-1:0]     energy
);
    import bbe_pkg::*;

    logic signed [SAMPLE_BITS-1:0] re_reg;
    logic signed [SAMPLE_BITS-1:0] im_reg;
    logic                          v1_reg;
    logic        [PWR_W-1:0]       sq_re_reg;
    logic        [PWR_W-1:0]       sq_im_reg;
    logic                          v2_reg;
    logic        [ACC_W-1:0]       energy_reg;
    logic        [ACC_W-1:0]       energy_next;

    logic [SAMPLE_BITS-1:0] mag_re;
    logic [SAMPLE_BITS-1:0] mag_im;
    logic [SUM_W-1:0]       sum;

    assign mag_re = re_reg[SAMPLE_BITS-1] ? (~re_reg + SAMPLE_BITS'(1)) : re_reg;
    assign mag_im = im_reg[SAMPLE_BITS-1] ? (~im_reg + SAMPLE_BITS'(1)) : im_reg;

    assign sum = SUM_W'(energy_reg) + SUM_W'(sq_re_reg) + SUM_W'(sq_im_reg);

    always_comb
    begin
        energy_next = energy_reg;
        if (cmd.clear)
        begin
            energy_next = '0;
        end
        else if (v2_reg)
        begin
            energy_next = (sum > SUM_W'(ENERGY_MAX)) ? ENERGY_MAX : sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            energy_reg <= '0;
        end
        else
        begin
            v1_reg     <= cmd.take;
            v2_reg     <= v1_reg;
            energy_reg <= energy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            re_reg <= real_part;
            im_reg <= imag_part;
        end
        if (v1_reg)
        begin
            sq_re_reg <= PWR_W'(mag_re) * PWR_W'(mag_re);
            sq_im_reg <= PWR_W'(mag_im) * PWR_W'(mag_im);
        end
    end

    assign sts.pipe_busy = v1_reg | v2_reg;
    assign energy        = energy_reg;

endmodule

[rtl/core/bbe_math.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bark band energy band arithmetic
// Bit-serial divider for the mean, normaliser and squaring logarithm for the
// decibel level, and the result register of the output stream.
// ----------------------------------------------------------------------------
module bbe_math (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bbe_pkg::math_cmd_t                  cmd,
    input  logic        [bbe_pkg::ACC_W-1:0]    energy,
    output bbe_pkg::math_sts_t                  sts,
    output logic        [bbe_pkg::BAND_BITS-1:0] band_number,
    output logic signed [bbe_pkg::VALUE_W-1:0]  band_value,
    output logic                                last_band
);
    import bbe_pkg::*;

    logic [ACC_W-1:0]     work_reg;
    logic [WIDTH_W-1:0]   rem_reg;
    logic [EXP_W-1:0]     exp_reg;
    logic [MANT_W-1:0]    m_reg;
    logic [FRAC_W-1:0]    f_reg;
    logic                 zero_reg;
    logic                 neg_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [LPROD_W-1:0]   prod_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [BAND_BITS-1:0] band_reg;
    logic                 last_reg;

    logic [WIDTH_W-1:0]      divisor;
    logic [WIDTH_W:0]        shifted;
    logic [WIDTH_W+1:0]      diff;
    logic [2*MANT_W-1:0]     sq;
    logic [MANT_W:0]         sq_top;
    logic signed [LOGL_W-1:0] lval;
    logic [LOGL_W-1:0]       labs;
    logic [LPROD_W:0]        rounded;
    logic [Q_W-1:0]          q;
    logic [VALUE_W-1:0]      log_value;
    logic [VALUE_W-1:0]      lin_value;
    logic [VALUE_W-1:0]      final_value;

    assign divisor = (BAND_WIDTH[cmd.band] == '0) ? WIDTH_W'(1) : BAND_WIDTH[cmd.band];
    assign shifted = {rem_reg, work_reg[ACC_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor};

    assign sq     = m_reg * m_reg;
    assign sq_top = sq[2*MANT_W-1:30];

    assign lval = $signed({2'b00, exp_reg, f_reg}) - $signed({2'b00, LOG_DEN[cmd.band]});
    assign labs = lval[LOGL_W-1] ? (~lval + LOGL_W'(1)) : lval;

    assign rounded   = {1'b0, prod_reg} + ROUND_HALF;
    assign q         = rounded[LPROD_W:30];
    assign log_value = neg_reg ? (~VALUE_W'(q) + VALUE_W'(1)) : VALUE_W'(q);
    assign lin_value = (work_reg > ACC_W'(LIN_MAX)) ? LIN_MAX : work_reg[VALUE_W-1:0];

    always_comb
    begin
        if (cmd.linear)
        begin
            final_value = lin_value;
        end
        else if (zero_reg)
        begin
            final_value = DB_FLOOR;
        end
        else
        begin
            final_value = log_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg  <= '0;
            rem_reg   <= '0;
            exp_reg   <= '0;
            m_reg     <= '0;
            f_reg     <= '0;
            zero_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            prod_reg  <= '0;
            value_reg <= '0;
            band_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                work_reg <= energy;
                rem_reg  <= '0;
                exp_reg  <= EXP_TOP;
                f_reg    <= '0;
                zero_reg <= (energy == '0);
            end
            else if (cmd.div_step)
            begin
                if (!diff[WIDTH_W+1])
                begin
                    rem_reg  <= diff[WIDTH_W-1:0];
                    work_reg <= {work_reg[ACC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= shifted[WIDTH_W-1:0];
                    work_reg <= {work_reg[ACC_W-2:0], 1'b0};
                end
            end
            else if (cmd.norm_step)
            begin
                if (work_reg[ACC_W-1])
                begin
                    m_reg <= work_reg[ACC_W-1:ACC_W-MANT_W];
                end
                else
                begin
                    work_reg <= {work_reg[ACC_W-2:0], 1'b0};
                    exp_reg  <= exp_reg - EXP_W'(1);
                end
            end
            else if (cmd.sqr_step)
            begin
                if (sq_top[MANT_W])
                begin
                    m_reg              <= sq_top[MANT_W:1];
                    f_reg[cmd.sqr_bit] <= 1'b1;
                end
                else
                begin
                    m_reg <= sq_top[MANT_W-1:0];
                end
            end
            if (cmd.log_sub)
            begin
                neg_reg <= lval[LOGL_W-1];
                mag_reg <= labs[LOGL_W-1:8];
            end
            if (cmd.log_mul)
            begin
                prod_reg <= mag_reg * TEN_LOG10_2;
            end
            if (cmd.out_load)
            begin
                value_reg <= final_value;
                band_reg  <= cmd.band;
                last_reg  <= cmd.last;
            end
        end
    end

    assign sts.norm_top = work_reg[ACC_W-1];
    assign sts.is_zero  = zero_reg;

    assign band_number = band_reg;
    assign band_value  = value_reg;
    assign last_band   = last_reg;

endmodule

[rtl/core/bbe_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bark band energy controller
// Tracks bins and bands, sequences the band arithmetic and owns the handshakes.
// ----------------------------------------------------------------------------
module bbe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    output bbe_pkg::acc_cmd_t   acc_cmd,
    input  bbe_pkg::acc_sts_t   acc_sts,
    output bbe_pkg::math_cmd_t  math_cmd,
    input  bbe_pkg::math_sts_t  math_sts
);
    import bbe_pkg::*;

    typedef enum logic [2:0] {
        S_ACCUM,
        S_DRAIN,
        S_DIV,
        S_NORM,
        S_SQR,
        S_LSUB,
        S_LMUL,
        S_OUT
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [BAND_BITS-1:0] band_reg;
    logic [BAND_BITS-1:0] band_next;
    logic [WIDTH_W-1:0]   count_reg;
    logic [WIDTH_W-1:0]   count_next;
    logic                 linear_reg;
    logic                 linear_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic [WIDTH_W-1:0] band_width;
    logic [WIDTH_W-1:0] count_inc;

    assign band_width = (BAND_WIDTH[band_reg] == '0) ? WIDTH_W'(1) : BAND_WIDTH[band_reg];
    assign count_inc  = count_reg + WIDTH_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        band_next      = band_reg;
        count_next     = count_reg;
        linear_next    = cfg_wr_en ? cfg_wr_data : linear_reg;
        out_valid_next = out_valid_reg && !m_ready;

        s_ready  = 1'b0;
        acc_cmd  = '0;
        math_cmd = '0;
        math_cmd.linear  = linear_reg;
        math_cmd.band    = band_reg;
        math_cmd.last    = LAST_BAND[band_reg];
        math_cmd.sqr_bit = SQR_IDX_W'(SQR_STEPS - 1) - SQR_IDX_W'(cnt_reg);

        case (state_reg)
            S_ACCUM:
            begin
                s_ready      = 1'b1;
                acc_cmd.take = s_valid;
                if (s_valid)
                begin
                    if (count_inc == band_width)
                    begin
                        count_next = '0;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!acc_sts.pipe_busy)
                begin
                    math_cmd.load = 1'b1;
                    acc_cmd.clear = 1'b1;
                    cnt_next      = '0;
                    state_next    = linear_reg ? S_DIV : S_NORM;
                end
            end
            S_DIV:
            begin
                math_cmd.div_step = 1'b1;
                cnt_next          = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ACC_W - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_NORM:
            begin
                math_cmd.norm_step = 1'b1;
                if (math_sts.is_zero)
                begin
                    state_next = S_OUT;
                end
                else if (math_sts.norm_top)
                begin
                    cnt_next   = '0;
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                math_cmd.sqr_step = 1'b1;
                cnt_next          = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQR_STEPS - 1))
                begin
                    state_next = S_LSUB;
                end
            end
            S_LSUB:
            begin
                math_cmd.log_sub = 1'b1;
                state_next       = S_LMUL;
            end
            S_LMUL:
            begin
                math_cmd.log_mul = 1'b1;
                state_next       = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_ready)
                begin
                    math_cmd.out_load = 1'b1;
                    out_valid_next    = 1'b1;
                    band_next         = NEXT_BAND[band_reg];
                    state_next        = S_ACCUM;
                end
            end
            default:
            begin
                state_next = S_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACCUM;
            cnt_reg       <= '0;
            band_reg      <= FIRST_BAND;
            count_reg     <= '0;
            linear_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            band_reg      <= band_next;
            count_reg     <= count_next;
            linear_reg    <= linear_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    ap_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        math_cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("Result register loaded while a transaction was still pending.");

    ap_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        math_cmd.load |-> !acc_sts.pipe_busy)
        else $error("Band sum captured before the bin pipeline had drained.");

    ap_count_in_band: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < band_width)
        else $error("Bin count ran past the width of the current band.");

    ap_band_populated: assert property (@(posedge clk) disable iff (!rst_n)
        BAND_WIDTH[band_reg] != '0)
        else $error("Current band owns no bins.");

endmodule

[rtl/core/bark_band_energy_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bark band energy top level
// Sums bin power over each Bark band and streams the mean or the decibel level.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_axis    in         one FFT bin: real_part, imag_part
//  m_axis    out        one band: band_number, band_value, tlast on final band
//  cfg       in         linear_scale, 0 for decibels, 1 for linear mean
//
//  Within a band, bins are taken at one transaction per cycle.
//  The last bin of a band holds s_axis_tready low while the bin pipeline
//  drains, then through the division and output steps in linear mode, or
//  through normalisation, squaring, logarithm and output steps in decibel mode.
//  The output cycle waits while an earlier result is still held on m_axis.
//  Reset is asynchronous and active low; the band tables are constants.
module bark_band_energy_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bbe_pkg::S_TDATA_W-1:0] s_axis_tdata,  // real_part, imag_part
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bbe_pkg::M_TDATA_W-1:0] m_axis_tdata,  // band_number, band_value
    output logic                          m_axis_tlast,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data
);
    import bbe_pkg::*;

    acc_cmd_t  acc_cmd;
    acc_sts_t  acc_sts;
    math_cmd_t math_cmd;
    math_sts_t math_sts;

    logic        [ACC_W-1:0]     energy;
    logic        [BAND_BITS-1:0] band_number;
    logic signed [VALUE_W-1:0]   band_value;

    bbe_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .acc_cmd     (acc_cmd),
        .acc_sts     (acc_sts),
        .math_cmd    (math_cmd),
        .math_sts    (math_sts)
    );

    bbe_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (acc_cmd),
        .real_part (s_axis_tdata[SAMPLE_BITS-1:0]),
        .imag_part (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .sts       (acc_sts),
        .energy    (energy)
    );

    bbe_math u_math (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (math_cmd),
        .energy      (energy),
        .sts         (math_sts),
        .band_number (band_number),
        .band_value  (band_value),
        .last_band   (m_axis_tlast)
    );

    assign m_axis_tdata = M_TDATA_W'({band_value, band_number});

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bark band energy testbench
// Streams FFT bins into the block, first a few hand-picked bins and then
// random runs in both decibel and linear mode, and checks every band result
// against a predictor that rebuilds the band widths, the running sums and the
// fixed-point logarithm independently. Both stream sides idle at random, and
// the result side is held off for long stretches so that the input stalls.
// ----------------------------------------------------------------------------
module tb;
    import bbe_pkg::*;

    typedef longint unsigned u64_t;

    localparam int   CLK_PERIOD    = 20;
    localparam int   CYCLE_LIMIT   = 1000000;
    localparam int   SETTLE_CYCLES = 150;
    localparam int   LONG_HOLD     = 400;
    localparam int   PHASES        = 7;
    localparam int   RANDOM_BINS   = 1631;
    localparam int   PRINT_CAP     = 100;
    localparam u64_t ENERGY_CAP    = (u64_t'(1) << 57) - 1;
    localparam u64_t MEAN_CAP      = (u64_t'(1) << 49) - 1;
    localparam longint DB_SILENCE  = -24576;
    localparam u64_t DB_PER_OCTAVE = 197283;

    localparam longint ARCTAN_STEP [31] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1
    };

    localparam logic [SAMPLE_BITS-1:0] EDGE_RE [15] = '{
        24'h7fffff, 24'h800000, 24'h800000, 24'h000000, 24'h7fffff,
        24'hffffff, 24'h000001, 24'h000000, 24'h000001, 24'h555555,
        24'haaaaaa, 24'h800001, 24'h400000, 24'hffffff, 24'h123456
    };
    localparam logic [SAMPLE_BITS-1:0] EDGE_IM [15] = '{
        24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h000000,
        24'h000001, 24'hffffff, 24'h000000, 24'h000000, 24'haaaaaa,
        24'h555555, 24'h7ffffe, 24'hc00000, 24'hffffff, 24'hfedcba
    };

    typedef enum int {
        STYLE_ZERO,
        STYLE_SMALL,
        STYLE_EXTREME,
        STYLE_FULL
    } sample_style_t;

    typedef struct {
        logic [BAND_BITS-1:0] band_number;
        logic [VALUE_W-1:0]   band_value;
        logic                 last_band;
    } band_result_t;

    class band_scoreboard;
        int           band_width [BAND_COUNT];
        u64_t         energy;
        int           bin_count;
        int           band;
        bit           linear;
        band_result_t expected_bands [$];
        int           mismatches;
        int           checked;

        function new();
            bit found;
            build_widths();
            energy     = 0;
            bin_count  = 0;
            linear     = 0;
            mismatches = 0;
            checked    = 0;
            band       = next_band(0, found);
        endfunction

        function longint cordic_arctan(longint arg);
            longint x;
            longint y;
            longint ang;
            longint nx;
            int     k;
            if (arg <= 0)
            begin
                return 0;
            end
            x   = longint'(1) <<< 30;
            y   = arg;
            ang = 0;
            for (k = 0; k < 31; k++)
            begin
                if (y > 0)
                begin
                    nx  = x + (y >>> k);
                    y   = y - (x >>> k);
                    ang = ang + ARCTAN_STEP[k];
                end
                else
                begin
                    nx  = x - (y >>> k);
                    y   = y + (x >>> k);
                    ang = ang - ARCTAN_STEP[k];
                end
                x = nx;
            end
            return ang;
        endfunction

        function longint fixed_log2(u64_t v);
            int     msb;
            int     k;
            u64_t   m;
            longint frac;
            frac = 0;
            for (msb = 63; msb > 0 && v[msb] == 1'b0; msb--)
            begin
            end
            m = (msb > 30) ? (v >> (msb - 30)) : (v << (30 - msb));
            for (k = 30; k > 0; k--)
            begin
                m = (m * m) >> 30;
                if (m >= (u64_t'(2) << 30))
                begin
                    m    = m >> 1;
                    frac = frac | (longint'(1) <<< (k - 1));
                end
            end
            return (longint'(msb) <<< 30) + frac;
        endfunction

        function void build_widths();
            u64_t   i;
            u64_t   t;
            longint a1;
            longint a2;
            longint z;
            longint b;
            foreach (band_width[j])
            begin
                band_width[j] = 0;
            end
            for (i = 0; i < u64_t'(FFT_SIZE / 2); i++)
            begin
                a1 = longint'(((i * 64'd33516) << 30) / (64'd1000 * FFT_SIZE));
                t  = ((i * 64'd588) << 24) / (64'd100 * FFT_SIZE);
                a2 = longint'((t * t) >> 18);
                z  = 13 * cordic_arctan(a1) + ((7 * cordic_arctan(a2)) >>> 1);
                b  = (z < 0) ? 0 : (z >>> 30);
                if (b > BAND_COUNT - 1)
                begin
                    b = BAND_COUNT - 1;
                end
                band_width[b]++;
            end
        endfunction

        function int next_band(int from, output bit found);
            int j;
            found = 1'b0;
            for (j = from; j < BAND_COUNT; j++)
            begin
                if (band_width[j] != 0)
                begin
                    found = 1'b1;
                    return j;
                end
            end
            return 0;
        endfunction

        function void set_scale(bit value);
            linear = value;
        endfunction

        function int pending();
            return expected_bands.size();
        endfunction

        function void note_bin(logic [SAMPLE_BITS-1:0] re, logic [SAMPLE_BITS-1:0] im);
            longint       sr;
            longint       si;
            u64_t         pw;
            longint       lv;
            longint       val;
            u64_t         mag;
            u64_t         q;
            int           w;
            int           nb;
            bit           found;
            band_result_t r;
            sr = longint'($signed(re));
            si = longint'($signed(im));
            if (sr < 0)
            begin
                sr = -sr;
            end
            if (si < 0)
            begin
                si = -si;
            end
            pw = u64_t'(sr * sr + si * si);
            if (band >= BAND_COUNT)
            begin
                band = next_band(0, found);
            end
            if (pw > ENERGY_CAP - energy)
            begin
                energy = ENERGY_CAP;
            end
            else
            begin
                energy = energy + pw;
            end
            bin_count++;
            w = (band_width[band] == 0) ? 1 : band_width[band];
            if (bin_count < w)
            begin
                return;
            end
            if (linear)
            begin
                q   = energy / u64_t'(w);
                val = longint'((q > MEAN_CAP) ? MEAN_CAP : q);
            end
            else if (energy == 0)
            begin
                val = DB_SILENCE;
            end
            else
            begin
                lv  = fixed_log2(energy) - fixed_log2(u64_t'(w) * 96);
                mag = u64_t'((lv < 0) ? -lv : lv) >> 8;
                q   = (mag * DB_PER_OCTAVE + (u64_t'(1) << 29)) >> 30;
                val = (lv < 0) ? -longint'(q) : longint'(q);
            end
            r.band_number = BAND_BITS'(band);
            r.band_value  = val[VALUE_W-1:0];
            nb            = next_band(band + 1, found);
            r.last_band   = !found;
            if (found)
            begin
                band = nb;
            end
            else
            begin
                band = next_band(0, found);
            end
            energy    = 0;
            bin_count = 0;
            expected_bands.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            if (mismatches <= PRINT_CAP)
            begin
                $display("ERROR at band result %0d: %s is %0h, expected %0h",
                         checked, what, got, want);
            end
        endtask

        task check_band(logic [M_TDATA_W-1:0] data, logic last);
            band_result_t want;
            checked++;
            if (expected_bands.size() == 0)
            begin
                report("result with nothing expected, tdata", 64'(data), 64'd0);
                return;
            end
            want = expected_bands.pop_front();
            if (data[BAND_BITS-1:0] !== want.band_number)
            begin
                report("band_number", 64'(data[BAND_BITS-1:0]), 64'(want.band_number));
            end
            if (data[BAND_BITS+VALUE_W-1:BAND_BITS] !== want.band_value)
            begin
                report("band_value", 64'(data[BAND_BITS+VALUE_W-1:BAND_BITS]),
                       64'(want.band_value));
            end
            if (last !== want.last_band)
            begin
                report("last_band", 64'(last), 64'(want.last_band));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // real_part, imag_part
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // band_number, band_value
    logic                 m_axis_tlast;
    logic                 cfg_wr_en;
    logic                 cfg_wr_data;

    band_scoreboard sb = new();
    bit             tx_idle_on;
    bit             rx_idle_on;
    int             rx_hold_count;
    int             cycle_count;

    bark_band_energy_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("FAIL bark_band_energy_top");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(sample_style_t style);
        case (style)
            STYLE_ZERO:    return '0;
            STYLE_SMALL:   return SAMPLE_BITS'(int'($urandom_range(0, 31)) - 16);
            STYLE_EXTREME: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            default:       return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Each result is checked at the edge that accepts it; the ready line then
    // follows the random stall pattern or a requested long hold-off.
    initial
    begin
        int rx_wait;
        int hold_served;
        rx_wait       = 0;
        hold_served   = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_band(m_axis_tdata, m_axis_tlast);
            end
            if (hold_served != rx_hold_count)
            begin
                hold_served = rx_hold_count;
                rx_wait     = LONG_HOLD;
            end
            else if (rx_wait == 0 && rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                rx_wait = pick_gap();
            end
            if (rx_wait > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic push_bin(input logic [SAMPLE_BITS-1:0] re,
                            input logic [SAMPLE_BITS-1:0] im);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {im, re};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_bin(re, im);
    endtask

    task automatic write_scale(input bit value);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_scale(value);
    endtask

    task automatic run_phase(input int n_bins);
        int            sent;
        int            run_len;
        int            k;
        int            r;
        sample_style_t style;
        sent = 0;
        while (sent < n_bins)
        begin
            r       = $urandom_range(0, 9);
            style   = sample_style_t'((r == 0) ? STYLE_ZERO : (r == 1) ? STYLE_SMALL :
                                      (r == 2) ? STYLE_EXTREME : STYLE_FULL);
            run_len = $urandom_range(1, 40);
            for (k = 0; k < run_len && sent < n_bins; k++)
            begin
                push_bin(pick_sample(style), pick_sample(style));
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        bit found;
        int k;
        int ph;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 1'b0;
        rst_n         <= 1'b0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Decibel mode: a silent first band, then the corner values of the bins.
        write_scale(1'b0);
        for (k = 0; k < sb.band_width[sb.next_band(0, found)]; k++)
        begin
            push_bin('0, '0);
        end
        for (k = 0; k < 15; k++)
        begin
            push_bin(EDGE_RE[k], EDGE_IM[k]);
        end
        s_axis_tvalid <= 1'b0;

        for (ph = 0; ph < PHASES; ph++)
        begin
            write_scale((ph == PHASES - 1) ? 1'($urandom_range(0, 1)) : 1'(ph % 2 == 0));
            tx_idle_on = (ph % 3 != 2);
            rx_idle_on = (ph % 3 != 1);
            if (ph % 3 == 2)
            begin
                rx_hold_count++;
            end
            run_phase(RANDOM_BINS / PHASES);
        end

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("PASS bark_band_energy_top");
        end
        else
        begin
            $display("FAIL bark_band_energy_top");
        end
        $finish;
    end
endmodule

[bark_band_energy_top.f]
rtl/core/bbe_pkg.sv
rtl/core/bbe_accum.sv
rtl/core/bbe_math.sv
rtl/core/bbe_ctrl.sv
rtl/core/bark_band_energy_top.sv
test/tb.sv
